// ===== rtl/u8u16d_pkg.sv =====
// Package for the UTF-8 / UTF-16 stream decoder: transfer payload types,
// decode mode codes, code point constants and the UTF-8 lead byte decode.
// No dependencies.
package u8u16d_pkg;

	localparam logic [1:0] MODE_UTF8    = 2'd0;
	localparam logic [1:0] MODE_UTF16BE = 2'd1;
	localparam logic [1:0] MODE_UTF16LE = 2'd2;
	localparam logic [1:0] MODE_RAW     = 2'd3;

	localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [20:0] CP_MAX         = 21'h10FFFF;
	localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        malformed;
		logic        end_of_stream;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic        emit;
		logic        bad;
		logic [20:0] cp;
		logic [20:0] pv;
		logic [1:0]  pend;
	} lead_t;

	function automatic lead_t utf8_lead(input logic [7:0] b);
		lead_t l;
		l = '0;
		if (b < 8'hC0) begin
			l.emit = 1'b1;
			l.cp   = {13'd0, b};
		end else if (b < 8'hE0) begin
			l.pv   = {16'd0, b[4:0]};
			l.pend = 2'd1;
		end else if (b < 8'hF0) begin
			l.pv   = {17'd0, b[3:0]};
			l.pend = 2'd2;
		end else if (b < 8'hF8) begin
			l.pv   = {18'd0, b[2:0]};
			l.pend = 2'd3;
		end else begin
			l.emit = 1'b1;
			l.bad  = 1'b1;
			l.cp   = CP_REPLACEMENT;
		end
		return l;
	endfunction

endpackage

// ===== rtl/utf8_utf16_stream_decoder.sv =====
// Byte stream to Unicode code point decoder (UTF-8, UTF-16 BE/LE, raw bytes).
// Depends on u8u16d_pkg.
//
// Takes one byte per transfer on src and delivers code points on res. A byte
// is decoded in the cycle it is taken and its zero, one or two results land
// in a four-entry result queue; src_ready is high while the queue holds two
// entries or fewer, so a byte can be taken every cycle while res keeps up. res
// drains one result per cycle while res_ready is high, so bytes giving two
// results (some malformed input, end of stream after a partial sequence) limit
// throughput to the res rate. decode_mode is written through cfg_we/cfg_wdata
// by the user only while idle, unenforced; a write also clears decoding state.
module utf8_utf16_stream_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             src_valid,
	output logic             src_ready,
	input  u8u16d_pkg::in_t  src_item,
	output logic             res_valid,
	input  logic             res_ready,
	output u8u16d_pkg::out_t res_item
);
	import u8u16d_pkg::*;

	localparam int QDEPTH = 4;

	logic [1:0]  mode_q;
	logic [20:0] pv_q, pv_d;
	logic [1:0]  pend_q, pend_d;
	logic [1:0]  phase_q, phase_d;
	logic [9:0]  hs_q, hs_d;
	logic [7:0]  fub_q, fub_d;

	out_t        queue_q [QDEPTH];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  cnt_q;

	logic        accept, pop;
	logic [1:0]  n_res;
	out_t        r0, r1;
	lead_t       lead;
	logic [20:0] acc;
	logic [15:0] unit;
	logic [7:0]  b;
	logic        partial;

	assign accept    = src_valid && src_ready;
	assign pop       = res_valid && res_ready;
	assign src_ready = (cnt_q <= 3'd2);
	assign res_valid = (cnt_q != 3'd0);
	assign res_item  = queue_q[rd_ptr_q];

	assign b    = src_item.data_byte;
	assign lead = utf8_lead(b);
	assign acc  = {pv_q[14:0], b[5:0]};
	assign unit = (mode_q == MODE_UTF16LE) ? {b, fub_q} : {fub_q, b};

	always_comb begin
		n_res   = 2'd0;
		r0      = '0;
		r1      = '0;
		pv_d    = pv_q;
		pend_d  = pend_q;
		phase_d = phase_q;
		hs_d    = hs_q;
		fub_d   = fub_q;
		partial = 1'b0;
		if (src_item.kind) begin
			case (mode_q)
				MODE_UTF8: partial = (pend_q != 2'd0);
				MODE_RAW:  partial = 1'b0;
				default:   partial = (phase_q != 2'd0);
			endcase
			if (partial) begin
				r0    = '{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0};
				r1    = '{21'd0, 1'b0, 1'b1, 1'b0};
				n_res = 2'd2;
			end else begin
				r0    = '{21'd0, 1'b0, 1'b1, 1'b0};
				n_res = 2'd1;
			end
			pv_d    = '0;
			pend_d  = '0;
			phase_d = '0;
			hs_d    = '0;
			fub_d   = '0;
		end else begin
			case (mode_q)
				MODE_UTF8: begin
					if (pend_q == 2'd0) begin
						pv_d   = lead.pv;
						pend_d = lead.pend;
						if (lead.emit) begin
							r0    = '{lead.cp, lead.bad, 1'b0, 1'b0};
							n_res = 2'd1;
						end
					end else if (b[7:6] != 2'b10) begin
						// broken sequence: flag it, then restart on this byte
						r0     = '{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0};
						pv_d   = lead.pv;
						pend_d = lead.pend;
						if (lead.emit) begin
							r1    = '{lead.cp, lead.bad, 1'b0, 1'b0};
							n_res = 2'd2;
						end else begin
							n_res = 2'd1;
						end
					end else begin
						pend_d = pend_q - 2'd1;
						if (pend_q == 2'd1) begin
							n_res = 2'd1;
							if (acc > CP_MAX) begin
								r0 = '{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0};
							end else begin
								r0 = '{acc, 1'b0, 1'b0, 1'b0};
							end
							pv_d = '0;
						end else begin
							pv_d = acc;
						end
					end
				end
				MODE_UTF16BE, MODE_UTF16LE: begin
					if (!phase_q[0]) begin
						fub_d   = b;
						phase_d = phase_q + 2'd1;
					end else if (phase_q == 2'd1) begin
						phase_d = 2'd0;
						if (unit[15:10] == SURR_HIGH_TAG) begin
							hs_d    = unit[9:0];
							phase_d = 2'd2;
						end else if (unit[15:10] == SURR_LOW_TAG) begin
							r0    = '{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0};
							n_res = 2'd1;
						end else begin
							r0    = '{{5'd0, unit}, 1'b0, 1'b0, 1'b0};
							n_res = 2'd1;
						end
					end else begin
						phase_d = 2'd0;
						hs_d    = '0;
						if (unit[15:10] == SURR_LOW_TAG) begin
							r0    = '{CP_SUPP_BASE + {1'b0, hs_q, unit[9:0]},
								1'b0, 1'b0, 1'b0};
							n_res = 2'd1;
						end else begin
							r0    = '{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0};
							r1    = '{{5'd0, unit}, 1'b0, 1'b0, 1'b0};
							n_res = 2'd2;
						end
					end
				end
				MODE_RAW: begin
					r0    = '{{13'd0, b}, 1'b0, 1'b0, 1'b0};
					n_res = 2'd1;
				end
				default: begin
					n_res = 2'd0;
				end
			endcase
		end
		if (n_res == 2'd1) r0.last_of_run = 1'b1;
		if (n_res == 2'd2) r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UTF8;
			pv_q    <= '0;
			pend_q  <= '0;
			phase_q <= '0;
			hs_q    <= '0;
			fub_q   <= '0;
		end else if (cfg_we) begin
			mode_q  <= cfg_wdata;
			pv_q    <= '0;
			pend_q  <= '0;
			phase_q <= '0;
			hs_q    <= '0;
			fub_q   <= '0;
		end else if (accept) begin
			pv_q    <= pv_d;
			pend_q  <= pend_d;
			phase_q <= phase_d;
			hs_q    <= hs_d;
			fub_q   <= fub_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + n_res;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) queue_q[wr_ptr_q] <= r0;
		if (accept && n_res == 2'd2) queue_q[wr_ptr_q + 2'd1] <= r1;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QDEPTH))
		else $error("result queue overflow");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.end_of_stream |-> res_item.last_of_run)
		else $error("end-of-stream result not last of its run");

	a_bad_repl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.malformed |-> res_item.code_point == CP_REPLACEMENT)
		else $error("malformed result without replacement code point");

	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_item.kind |=> pend_q == 2'd0 && phase_q == 2'd0)
		else $error("decoder state not cleared after end of stream");
`endif

endmodule

// ===== sim/utf8_utf16_stream_decoder_tb.sv =====
// Self-checking testbench for utf8_utf16_stream_decoder: a directed table, then
// random byte streams in every decode mode, checked against an in-bench decoder.
// Depends on u8u16d_pkg and the decoder RTL.
module utf8_utf16_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16d_pkg::*;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;
	localparam int   PHASE_LEN = 194;
	localparam logic [1:0] PHASE_MODES [8] = '{MODE_UTF8, MODE_UTF16BE, MODE_UTF16LE, MODE_RAW,
		MODE_UTF8, MODE_UTF16LE, MODE_UTF16BE, MODE_UTF8};

	typedef struct {
		logic       is_cfg;
		logic [1:0] mode;
		in_t        item;
		int         n_typed;
		out_t       t0;
		out_t       t1;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic       src_valid = 1'b0;
	logic       src_ready;
	in_t        src_item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	out_t       res_item;

	bit   failed;
	bit   calm;
	int   bytes_sent;
	out_t pending_cps[$];
	row_t plan[$];

	// in-bench decoder state
	logic [1:0]  m_mode;
	logic [20:0] utf8_acc;
	logic [1:0]  utf8_left;
	logic [1:0]  u16_phase;
	logic [15:0] u16_high;
	logic [7:0]  u16_first;
	out_t        step_res[2];
	int          step_n;

	utf8_utf16_stream_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= calm || ($urandom_range(99) >= 36);
	end

	function automatic void emit(logic [20:0] cp, logic bad, logic eos);
		step_res[step_n] = out_t'{cp, bad, eos, 1'b0};
		step_n++;
	endfunction

	function automatic void clear_decoder();
		utf8_acc  = '0;
		utf8_left = '0;
		u16_phase = '0;
		u16_high  = '0;
		u16_first = '0;
	endfunction

	function automatic void utf8_start(logic [7:0] b);
		if (b < 8'hC0) begin
			emit({13'd0, b}, 1'b0, 1'b0);
		end else if (b < 8'hE0) begin
			utf8_acc  = {16'd0, b[4:0]};
			utf8_left = 2'd1;
		end else if (b < 8'hF0) begin
			utf8_acc  = {17'd0, b[3:0]};
			utf8_left = 2'd2;
		end else if (b < 8'hF8) begin
			utf8_acc  = {18'd0, b[2:0]};
			utf8_left = 2'd3;
		end else begin
			emit(CP_REPLACEMENT, 1'b1, 1'b0);
		end
	endfunction

	// Fills step_res/step_n with the results one accepted item produces.
	function automatic void decode_step(in_t it);
		logic [7:0]  b;
		logic [15:0] u;
		b = it.data_byte;
		step_n = 0;
		if (it.kind == KIND_EOS) begin
			if ((m_mode == MODE_UTF8 && utf8_left != 0) ||
			    ((m_mode == MODE_UTF16BE || m_mode == MODE_UTF16LE) && u16_phase != 0))
				emit(CP_REPLACEMENT, 1'b1, 1'b0);
			emit('0, 1'b0, 1'b1);
			clear_decoder();
		end else begin
			case (m_mode)
				MODE_UTF8: begin
					if (utf8_left == 0) begin
						utf8_start(b);
					end else if (b[7:6] != 2'b10) begin
						emit(CP_REPLACEMENT, 1'b1, 1'b0);
						utf8_acc  = '0;
						utf8_left = '0;
						utf8_start(b);
					end else begin
						utf8_acc  = {utf8_acc[14:0], b[5:0]};
						utf8_left = utf8_left - 2'd1;
						if (utf8_left == 0) begin
							if (utf8_acc > CP_MAX)
								emit(CP_REPLACEMENT, 1'b1, 1'b0);
							else
								emit(utf8_acc, 1'b0, 1'b0);
							utf8_acc = '0;
						end
					end
				end
				MODE_UTF16BE, MODE_UTF16LE: begin
					if (!u16_phase[0]) begin
						u16_first = b;
						u16_phase = u16_phase + 2'd1;
					end else begin
						u = (m_mode == MODE_UTF16LE) ? {b, u16_first} : {u16_first, b};
						if (u16_phase == 2'd1) begin
							u16_phase = '0;
							if (u[15:10] == SURR_HIGH_TAG) begin
								u16_high  = u;
								u16_phase = 2'd2;
							end else if (u[15:10] == SURR_LOW_TAG) begin
								emit(CP_REPLACEMENT, 1'b1, 1'b0);
							end else begin
								emit({5'd0, u}, 1'b0, 1'b0);
							end
						end else begin
							u16_phase = '0;
							if (u[15:10] == SURR_LOW_TAG) begin
								emit(CP_SUPP_BASE + 21'({u16_high[9:0], u[9:0]}), 1'b0, 1'b0);
							end else begin
								emit(CP_REPLACEMENT, 1'b1, 1'b0);
								emit({5'd0, u}, 1'b0, 1'b0);
							end
							u16_high = '0;
						end
					end
				end
				default: emit({13'd0, b}, 1'b0, 1'b0);
			endcase
		end
		if (step_n > 0)
			step_res[step_n - 1].last_of_run = 1'b1;
	endfunction

	function automatic void add_row(logic is_cfg, logic [1:0] mode, logic kind, logic [7:0] b,
			int n_typed = -1, out_t t0 = '0, out_t t1 = '0);
		row_t r;
		r.is_cfg  = is_cfg;
		r.mode    = mode;
		r.item    = in_t'{kind, b};
		r.n_typed = n_typed;
		r.t0      = t0;
		r.t1      = t1;
		plan.push_back(r);
	endfunction

	// Presents one item, waits for the transfer, then records what it should produce.
	// Typed expectations, when given, stand in for the decoder's own.
	task automatic send_item(input in_t it, input int n_typed = -1,
			input out_t t0 = '0, input out_t t1 = '0);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 36)
			gap++;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		bytes_sent++;
		decode_step(it);
		if (n_typed >= 0) begin
			if (n_typed > 0)
				pending_cps.push_back(t0);
			if (n_typed > 1)
				pending_cps.push_back(t1);
		end else begin
			for (int k = 0; k < step_n; k++)
				pending_cps.push_back(step_res[k]);
		end
	endtask

	task automatic write_mode(input logic [1:0] m);
		src_valid <= 1'b0;
		while (pending_cps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_mode = m;
		clear_decoder();
	endtask

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_cps.size() == 0) begin
				$error("result with none expected: %h", res_item);
				failed = 1'b1;
			end else begin
				want = pending_cps.pop_front();
				if (res_item.code_point !== want.code_point) begin
					$error("code_point: expected %h, got %h", want.code_point, res_item.code_point);
					failed = 1'b1;
				end
				if (res_item.malformed !== want.malformed) begin
					$error("malformed: expected %b, got %b", want.malformed, res_item.malformed);
					failed = 1'b1;
				end
				if (res_item.end_of_stream !== want.end_of_stream) begin
					$error("end_of_stream: expected %b, got %b",
						want.end_of_stream, res_item.end_of_stream);
					failed = 1'b1;
				end
				if (res_item.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run, res_item.last_of_run);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int          r;
		int          len;
		int          keep;
		int          phase_end;
		logic [20:0] cp;
		logic [7:0]  seq[$];
		logic [15:0] units[$];
		logic [15:0] u;

		m_mode = MODE_UTF8;
		clear_decoder();

		// UTF-8 after reset
		add_row(0, 0, KIND_DATA, 8'h00, 1, out_t'{21'h0, 1'b0, 1'b0, 1'b1});
		add_row(0, 0, KIND_DATA, 8'hBF, 1, out_t'{21'hBF, 1'b0, 1'b0, 1'b1});
		add_row(0, 0, KIND_DATA, 8'hFF, 1, out_t'{CP_REPLACEMENT, 1'b1, 1'b0, 1'b1});
		add_row(0, 0, KIND_DATA, 8'hF8, 1, out_t'{CP_REPLACEMENT, 1'b1, 1'b0, 1'b1});
		add_row(0, 0, KIND_DATA, 8'hF4);
		add_row(0, 0, KIND_DATA, 8'h90);
		add_row(0, 0, KIND_DATA, 8'h80);
		add_row(0, 0, KIND_DATA, 8'h80);
		add_row(0, 0, KIND_DATA, 8'hE2);
		add_row(0, 0, KIND_DATA, 8'h28);
		add_row(0, 0, KIND_DATA, 8'hF0);
		add_row(0, 0, KIND_EOS, 8'hA5, 2, out_t'{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0},
			out_t'{21'h0, 1'b0, 1'b1, 1'b1});
		add_row(0, 0, KIND_EOS, 8'h00, 1, out_t'{21'h0, 1'b0, 1'b1, 1'b1});
		// UTF-16 BE: pair, lone low, high then plain unit
		add_row(1, MODE_UTF16BE, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'hD8);
		add_row(0, 0, KIND_DATA, 8'h3D);
		add_row(0, 0, KIND_DATA, 8'hDE);
		add_row(0, 0, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'hDC);
		add_row(0, 0, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'hD8);
		add_row(0, 0, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'h41);
		// UTF-16 LE: half unit at end of stream
		add_row(1, MODE_UTF16LE, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'h12);
		add_row(0, 0, KIND_EOS, 8'hFF, 2, out_t'{CP_REPLACEMENT, 1'b1, 1'b0, 1'b0},
			out_t'{21'h0, 1'b0, 1'b1, 1'b1});
		// raw bytes
		add_row(1, MODE_RAW, KIND_DATA, 8'h00);
		add_row(0, 0, KIND_DATA, 8'hFF, 1, out_t'{21'hFF, 1'b0, 1'b0, 1'b1});
		add_row(0, 0, KIND_EOS, 8'h5A, 1, out_t'{21'h0, 1'b0, 1'b1, 1'b1});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_mode(plan[i].mode);
			else
				send_item(plan[i].item, plan[i].n_typed, plan[i].t0, plan[i].t1);
		end

		for (int ph = 0; ph < 8; ph++) begin
			write_mode(PHASE_MODES[ph]);
			calm = (ph == 4);
			phase_end = bytes_sent + PHASE_LEN;
			while (bytes_sent < phase_end) begin
				r = $urandom_range(99);
				case (m_mode)
					MODE_UTF8: begin
						if (r < 70) begin
							len = $urandom_range(1, 4);
							seq.delete();
							case (len)
								1: begin
									cp = 21'($urandom_range(0, 'h7F));
									seq.push_back({1'b0, cp[6:0]});
								end
								2: begin
									cp = 21'($urandom_range(0, 'h7FF));
									seq.push_back({3'b110, cp[10:6]});
								end
								3: begin
									cp = 21'($urandom_range(0, 'hFFFF));
									seq.push_back({4'b1110, cp[15:12]});
								end
								default: begin
									cp = ($urandom_range(3) == 0)
										? 21'($urandom_range(0, 'h1FFFFF))
										: 21'($urandom_range(0, 'h10FFFF));
									seq.push_back({5'b11110, cp[20:18]});
									seq.push_back({2'b10, cp[17:12]});
								end
							endcase
							if (len >= 3)
								seq.push_back({2'b10, cp[11:6]});
							if (len >= 2)
								seq.push_back({2'b10, cp[5:0]});
							keep = (r < 60 || len == 1) ? len : $urandom_range(1, len - 1);
							for (int k = 0; k < keep; k++)
								send_item(in_t'{KIND_DATA, seq[k]});
						end else if (r < 94) begin
							send_item(in_t'{KIND_DATA, 8'($urandom)});
						end else begin
							send_item(in_t'{KIND_EOS, 8'($urandom)});
						end
					end
					MODE_UTF16BE, MODE_UTF16LE: begin
						units.delete();
						if (r < 45) begin
							u = 16'($urandom);
							if (u[15:11] == 5'b11011)
								u[15] = 1'b0;
							units.push_back(u);
						end else if (r < 75) begin
							units.push_back({SURR_HIGH_TAG, 10'($urandom)});
							units.push_back({SURR_LOW_TAG, 10'($urandom)});
						end else if (r < 82) begin
							units.push_back({SURR_LOW_TAG, 10'($urandom)});
						end else if (r < 89) begin
							units.push_back({SURR_HIGH_TAG, 10'($urandom)});
							units.push_back(16'($urandom));
						end else if (r < 94) begin
							send_item(in_t'{KIND_DATA, 8'($urandom)});
						end else begin
							send_item(in_t'{KIND_EOS, 8'($urandom)});
						end
						foreach (units[k]) begin
							if (m_mode == MODE_UTF16BE) begin
								send_item(in_t'{KIND_DATA, units[k][15:8]});
								send_item(in_t'{KIND_DATA, units[k][7:0]});
							end else begin
								send_item(in_t'{KIND_DATA, units[k][7:0]});
								send_item(in_t'{KIND_DATA, units[k][15:8]});
							end
						end
					end
					default: begin
						if (r < 90)
							send_item(in_t'{KIND_DATA, 8'($urandom)});
						else
							send_item(in_t'{KIND_EOS, 8'($urandom)});
					end
				endcase
			end
		end
		calm = 1'b0;
		src_valid <= 1'b0;

		while (pending_cps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failed) begin
			$display("*** FAILED ***");
		end else begin
			$display("*** PASSED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/u8u16d_pkg.sv
rtl/utf8_utf16_stream_decoder.sv
sim/utf8_utf16_stream_decoder_tb.sv
